/* hdl/twr_pkg.sv */
package twr_pkg;

    // default word buffer depth
    localparam int WORD_CAPACITY_DEF = 32;

    // cap on characters sent for one transaction
    localparam int MAX_RESULTS = 40;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // line width handling
    localparam logic [7:0] MIN_WIDTH   = 8'd16;
    localparam logic [7:0] WIDTH_RESET = 8'd32;
    localparam logic [8:0] WRAP_SLACK  = 9'd8;
    localparam logic [7:0] SCOL_MAX    = 8'd255;
    localparam logic [7:0] BASIC_COLS  = 8'd4;

    // byte classes
    localparam logic [7:0] LEAD_C3   = 8'hC3;
    localparam logic [7:0] LEAD_MIN  = 8'hC0;
    localparam logic [7:0] NON_ASCII = 8'h80;

    // characters
    localparam logic [6:0] CH_NONE  = 7'd0;
    localparam logic [6:0] CH_NL    = 7'd10;
    localparam logic [6:0] CH_SPACE = 7'd32;
    localparam logic [6:0] CH_DASH  = 7'd45;
    localparam logic [6:0] CH_ZERO  = 7'd48;
    localparam logic [6:0] CH_NINE  = 7'd57;
    localparam logic [6:0] CH_MAX   = 7'd126;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_END     = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    // numbered-line detection
    typedef enum logic [1:0] {
        BD_NONE   = 2'd0,
        BD_DIGITS = 2'd1,
        BD_BASIC  = 2'd2,
        BD_NOT    = 2'd3
    } t_basic;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EW_CHECK,
        ST_EW_SPACE,
        ST_EW_CHARS,
        ST_EW_BREAK,
        ST_POST_SETTLE,
        ST_POST_BLANK,
        ST_CHAR,
        ST_TAIL_SPACE,
        ST_TAIL_BREAK,
        ST_FINISH
    } t_state;

    // sequencer to output stage
    typedef struct packed {
        logic       emit;
        logic [6:0] ch;
        logic       fin;
    } t_emit_req;

    // output stage to sequencer
    typedef struct packed {
        logic emit_ok;
        logic fin_ok;
    } t_out_stat;

    // base letter of a C3-led accented letter, zero if none
    function automatic logic [6:0] accent_base(input logic [7:0] b);
        logic [6:0] r;
        r = CH_NONE;
        if (b >= 8'h80 && b <= 8'h85) r = 7'h41;
        else if (b == 8'h87) r = 7'h43;
        else if (b >= 8'h88 && b <= 8'h8B) r = 7'h45;
        else if (b >= 8'h8C && b <= 8'h8F) r = 7'h49;
        else if (b == 8'h91) r = 7'h4E;
        else if (b >= 8'h92 && b <= 8'h96) r = 7'h4F;
        else if (b >= 8'h99 && b <= 8'h9C) r = 7'h55;
        else if (b >= 8'hA0 && b <= 8'hA5) r = 7'h61;
        else if (b == 8'hA7) r = 7'h63;
        else if (b >= 8'hA8 && b <= 8'hAB) r = 7'h65;
        else if (b >= 8'hAC && b <= 8'hAF) r = 7'h69;
        else if (b == 8'hB1) r = 7'h6E;
        else if (b >= 8'hB2 && b <= 8'hB6) r = 7'h6F;
        else if (b >= 8'hB9 && b <= 8'hBC) r = 7'h75;
        return r;
    endfunction

endpackage

/* hdl/twr_word_buf.sv */
module twr_word_buf #(
    parameter int DEPTH = twr_pkg::WORD_CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [6:0]               i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [6:0]               o_rd_data
);

    logic [6:0] r_mem [DEPTH];
    logic [6:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/twr_out_stage.sv */
module twr_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twr_pkg::t_emit_req  i_req,
    output twr_pkg::t_out_stat  o_stat,
    output logic                o_valid,
    output logic [6:0]          o_char,
    output logic                o_last,
    input  logic                i_ready
);

    import twr_pkg::*;

    logic       r_pend_valid;
    logic [6:0] r_pend_char;
    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_out_last;
    logic       out_free;

    assign out_free       = !r_out_valid || i_ready;
    assign o_stat.emit_ok = !r_pend_valid || out_free;
    assign o_stat.fin_ok  = !r_pend_valid || out_free;

    // control: the newest character waits in the pending slot until its
    // successor or the end of the transaction says whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_req.emit && o_stat.emit_ok) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end else if (i_ready) begin
                    r_out_valid <= 1'b0;
                end
            end else if (i_req.fin && r_pend_valid && out_free) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_req.emit && o_stat.emit_ok) begin
            r_pend_char <= i_req.ch;
            if (r_pend_valid) begin
                r_out_char <= r_pend_char;
                r_out_last <= 1'b0;
            end
        end else if (i_req.fin && r_pend_valid && out_free) begin
            r_out_char <= r_pend_char;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

/* hdl/twr_ctrl.sv */
module twr_ctrl #(
    parameter int WORD_CAPACITY = twr_pkg::WORD_CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  twr_pkg::t_cmd                    i_cmd,
    input  logic [7:0]                       i_byte,
    input  logic [7:0]                       i_line_width,
    output logic                             o_ready,
    output twr_pkg::t_emit_req               o_emit,
    input  twr_pkg::t_out_stat               i_stat,
    output logic                             o_wr_en,
    output logic [$clog2(WORD_CAPACITY)-1:0] o_wr_addr,
    output logic [6:0]                       o_wr_data,
    output logic [$clog2(WORD_CAPACITY)-1:0] o_rd_addr,
    input  logic [6:0]                       i_rd_data
);

    import twr_pkg::*;

    localparam int AW = $clog2(WORD_CAPACITY);
    localparam int LW = $clog2(WORD_CAPACITY + 1);
    localparam logic [LW-1:0] CAP = LW'(WORD_CAPACITY);

    t_state          r_state, n_state;
    t_state          r_ret, n_ret;
    t_cmd            r_cmd;
    logic [7:0]      r_byte;
    logic [6:0]      r_ch, n_ch;
    logic [LW-1:0]   r_wl, n_wl;
    logic [LW-1:0]   r_pos, n_pos;
    logic [7:0]      r_col, n_col;
    logic            r_sp, n_sp;
    logic [1:0]      r_nlc, n_nlc;
    logic [7:0]      r_lead, n_lead;
    logic [7:0]      r_scol, n_scol;
    logic [7:0]      r_psl, n_psl;
    t_basic          r_bd, n_bd;
    logic            r_pwb, n_pwb;
    logic            r_settle_sp, n_settle_sp;
    logic            r_settle_n2, n_settle_n2;
    logic [RES_W-1:0] r_res_cnt, n_res_cnt;

    logic [7:0]      w_eff;
    logic [LW-1:0]   rest;
    logic [9:0]      fit_sum;
    logic            fits;
    logic            wrapping;
    logic            send_ok;
    logic            emit_want;
    logic [6:0]      emit_ch;
    logic            dec_keep;
    logic [6:0]      dec_ch;
    logic            deliberate;

    // shared width arithmetic
    assign w_eff    = (i_line_width < MIN_WIDTH) ? MIN_WIDTH : i_line_width;
    assign rest     = r_wl - r_pos;
    assign fit_sum  = 10'(r_col) + 10'(r_sp) + 10'(rest);
    assign fits     = fit_sum <= 10'(w_eff);
    assign wrapping = (9'(r_psl) + WRAP_SLACK) >= 9'(w_eff);
    assign send_ok  = (r_res_cnt >= RES_W'(MAX_RESULTS)) || i_stat.emit_ok;

    // byte classification ahead of the word logic
    always_comb begin
        dec_keep = 1'b0;
        dec_ch   = r_byte[6:0];
        n_lead   = r_lead;
        if (r_lead != 8'd0) begin
            n_lead = 8'd0;
            dec_ch = accent_base(r_byte);
            dec_keep = (r_lead == LEAD_C3) && (dec_ch != CH_NONE);
        end else if (r_byte >= LEAD_MIN) begin
            n_lead = r_byte;
        end else if (r_byte < NON_ASCII) begin
            dec_keep = 1'b1;
        end
    end

    assign deliberate = (dec_ch == CH_DASH && r_wl == '0) || r_pwb || !wrapping;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_FINISH;
            r_wl        <= '0;
            r_pos       <= '0;
            r_col       <= '0;
            r_sp        <= 1'b0;
            r_nlc       <= '0;
            r_lead      <= '0;
            r_scol      <= '0;
            r_psl       <= '0;
            r_bd        <= BD_NONE;
            r_pwb       <= 1'b0;
            r_settle_sp <= 1'b0;
            r_settle_n2 <= 1'b0;
            r_res_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_wl        <= n_wl;
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_sp        <= n_sp;
            r_nlc       <= n_nlc;
            if (r_state == ST_DECODE && r_cmd == CMD_BYTE) begin
                r_lead <= n_lead;
            end else if (r_state == ST_DECODE && r_cmd == CMD_RESTART) begin
                r_lead <= '0;
            end
            r_scol      <= n_scol;
            r_psl       <= n_psl;
            r_bd        <= n_bd;
            r_pwb       <= n_pwb;
            r_settle_sp <= n_settle_sp;
            r_settle_n2 <= n_settle_n2;
            r_res_cnt   <= n_res_cnt;
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd  <= i_cmd;
            r_byte <= i_byte;
        end
        r_ch <= n_ch;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_ch        = r_ch;
        n_wl        = r_wl;
        n_pos       = r_pos;
        n_col       = r_col;
        n_sp        = r_sp;
        n_nlc       = r_nlc;
        n_scol      = r_scol;
        n_psl       = r_psl;
        n_bd        = r_bd;
        n_pwb       = r_pwb;
        n_settle_sp = r_settle_sp;
        n_settle_n2 = r_settle_n2;
        n_res_cnt   = r_res_cnt;
        emit_want   = 1'b0;
        emit_ch     = CH_NONE;
        o_wr_en     = 1'b0;
        o_emit.fin  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_res_cnt = '0;
                    n_state   = ST_DECODE;
                end
            end

            ST_DECODE: begin
                case (r_cmd)
                    CMD_BYTE: begin
                        n_state = ST_FINISH;
                        if (dec_keep && dec_ch == CH_NL) begin
                            if (r_nlc == 2'd0) begin
                                n_psl = r_scol;
                                n_pwb = (r_bd == BD_BASIC);
                            end
                            if (r_nlc != 2'd2) begin
                                n_nlc = r_nlc + 2'd1;
                            end
                            n_scol = '0;
                            n_bd   = BD_NONE;
                        end else if (dec_keep && dec_ch >= CH_SPACE && dec_ch <= CH_MAX) begin
                            n_ch = dec_ch;
                            // numbered-line tracking
                            if (r_bd != BD_BASIC) begin
                                if (dec_ch >= CH_ZERO && dec_ch <= CH_NINE) begin
                                    if (r_scol < BASIC_COLS) begin
                                        n_bd = BD_DIGITS;
                                    end
                                end else if (dec_ch == CH_SPACE && r_bd == BD_DIGITS) begin
                                    n_bd = BD_BASIC;
                                end else begin
                                    n_bd = BD_NOT;
                                end
                            end
                            if (r_scol != SCOL_MAX) begin
                                n_scol = r_scol + 8'd1;
                            end
                            // pending newlines are settled before the character
                            if (r_nlc != 2'd0) begin
                                n_settle_sp = (r_nlc == 2'd1) && !deliberate;
                                n_settle_n2 = (r_nlc == 2'd2);
                                n_nlc       = '0;
                                n_ret       = ST_POST_SETTLE;
                                n_state     = ST_EW_CHECK;
                            end else begin
                                n_state = ST_CHAR;
                            end
                        end
                    end
                    CMD_END: begin
                        n_nlc   = '0;
                        n_scol  = '0;
                        n_ret   = ST_TAIL_BREAK;
                        n_state = ST_EW_CHECK;
                    end
                    CMD_RESTART: begin
                        n_wl    = '0;
                        n_pos   = '0;
                        n_col   = '0;
                        n_sp    = 1'b0;
                        n_nlc   = '0;
                        n_scol  = '0;
                        n_psl   = '0;
                        n_bd    = BD_NONE;
                        n_pwb   = 1'b0;
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            // word flush: decide what the next piece of the word needs
            ST_EW_CHECK: begin
                if (r_pos == r_wl) begin
                    n_wl    = '0;
                    n_pos   = '0;
                    n_state = r_ret;
                end else if (r_col == 8'd0) begin
                    n_state = ST_EW_CHARS;
                end else if (fits) begin
                    n_state = r_sp ? ST_EW_SPACE : ST_EW_CHARS;
                end else begin
                    n_state = ST_EW_BREAK;
                end
            end

            ST_EW_SPACE: begin
                emit_want = 1'b1;
                emit_ch   = CH_SPACE;
                if (send_ok) begin
                    n_col   = r_col + 8'd1;
                    n_sp    = 1'b0;
                    n_state = ST_EW_CHARS;
                end
            end

            // one buffered character per cycle, unless the output stage stalls it, until word end or line full
            ST_EW_CHARS: begin
                emit_want = 1'b1;
                emit_ch   = i_rd_data;
                if (send_ok) begin
                    n_pos = r_pos + LW'(1);
                    n_col = r_col + 8'd1;
                    n_sp  = 1'b0;
                    if ((r_pos + LW'(1) == r_wl) || (r_col + 8'd1 == w_eff)) begin
                        n_state = ST_EW_CHECK;
                    end
                end
            end

            ST_EW_BREAK: begin
                emit_want = 1'b1;
                emit_ch   = CH_NL;
                if (send_ok) begin
                    n_col   = '0;
                    n_sp    = 1'b0;
                    n_state = ST_EW_CHECK;
                end
            end

            // a single soft newline becomes a space, otherwise a break
            ST_POST_SETTLE: begin
                if (r_settle_sp) begin
                    if (r_col != 8'd0) begin
                        n_sp = 1'b1;
                    end
                    n_state = ST_CHAR;
                end else if (r_col != 8'd0) begin
                    emit_want = 1'b1;
                    emit_ch   = CH_NL;
                    if (send_ok) begin
                        n_col   = '0;
                        n_sp    = 1'b0;
                        n_state = ST_POST_BLANK;
                    end
                end else begin
                    n_state = ST_POST_BLANK;
                end
            end

            // two or more newlines give a blank line
            ST_POST_BLANK: begin
                if (r_settle_n2) begin
                    emit_want = 1'b1;
                    emit_ch   = CH_NL;
                    if (send_ok) begin
                        n_col   = '0;
                        n_sp    = 1'b0;
                        n_state = ST_CHAR;
                    end
                end else begin
                    n_state = ST_CHAR;
                end
            end

            ST_CHAR: begin
                if (r_ch == CH_SPACE) begin
                    n_ret   = ST_TAIL_SPACE;
                    n_state = ST_EW_CHECK;
                end else begin
                    o_wr_en = 1'b1;
                    n_wl    = r_wl + LW'(1);
                    if (r_wl + LW'(1) == CAP) begin
                        n_ret   = ST_FINISH;
                        n_state = ST_EW_CHECK;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end

            ST_TAIL_SPACE: begin
                if (r_col != 8'd0) begin
                    n_sp = 1'b1;
                end
                n_state = ST_FINISH;
            end

            ST_TAIL_BREAK: begin
                if (r_col != 8'd0) begin
                    emit_want = 1'b1;
                    emit_ch   = CH_NL;
                    if (send_ok) begin
                        n_col   = '0;
                        n_sp    = 1'b0;
                        n_state = ST_FINISH;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end

            // mark the held character as last and release it
            ST_FINISH: begin
                o_emit.fin = 1'b1;
                if (i_stat.fin_ok) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_emit.emit = emit_want && (r_res_cnt < RES_W'(MAX_RESULTS));
        o_emit.ch   = emit_ch;
        if (o_emit.emit && i_stat.emit_ok) begin
            n_res_cnt = r_res_cnt + RES_W'(1);
        end
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_wr_addr = r_wl[AW-1:0];
    assign o_wr_data = r_ch;
    assign o_rd_addr = (n_pos < CAP) ? n_pos[AW-1:0] : '0;

endmodule

/* hdl/text_word_wrapper.sv */
// Greedy word wrapper for a stream of UTF-8 text. Each input transaction
// carries a command in tuser (byte, end of text, restart) and a source byte
// in tdata; the block answers with a run of output characters, the final one
// flagged by tlast, and transactions that cause no output give none. Input is
// taken one transaction at a time: tready is high only while the sequencer
// is idle. A byte that is dropped, stored in the word buffer or turned into
// newline state passes the accept and decode steps and ends in the finish
// step. When a word is flushed, the sequencer sends one character per cycle
// from the single read port of the word buffer; a full output register with
// tready low stalls it. The line width register may be written only while no
// transaction is in progress.
module text_word_wrapper #(
    parameter int WORD_CAPACITY = twr_pkg::WORD_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: line width
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    // slave side
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] byte_in
    input  logic [1:0] i_s_tuser,   // [1:0] command
    // master side
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] out_char, [7] zero
    output logic       o_m_tlast
);

    import twr_pkg::*;

    localparam int AW = $clog2(WORD_CAPACITY);

    logic [7:0]   r_line_width;
    logic         start;
    t_emit_req    emit_req;
    t_out_stat    out_stat;
    logic         wr_en;
    logic [AW-1:0] wr_addr;
    logic [6:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [6:0]   rd_data;
    logic [6:0]   out_char;

    // line width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_line_width <= i_cfg_data;
        end
    end

    assign start = i_s_tvalid && o_s_tready;

    // sequencer
    twr_ctrl #(
        .WORD_CAPACITY(WORD_CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (t_cmd'(i_s_tuser)),
        .i_byte       (i_s_tdata),
        .i_line_width (r_line_width),
        .o_ready      (o_s_tready),
        .o_emit       (emit_req),
        .i_stat       (out_stat),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    // word buffer
    twr_word_buf #(
        .DEPTH(WORD_CAPACITY)
    ) u_word_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // pending character and output register
    twr_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (emit_req),
        .o_stat  (out_stat),
        .o_valid (o_m_tvalid),
        .o_char  (out_char),
        .o_last  (o_m_tlast),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {1'b0, out_char};

    // a transaction keeps the input side closed for at least the decode cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !o_s_tready)
        else $error("input accepted again right after a transaction");

    // only newline and printable characters leave the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata == 8'd10) ||
                       (o_m_tdata >= 8'd32 && o_m_tdata <= 8'd126))
        else $error("output character out of range");

    // a stalled character request holds until the output stage takes it
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_req.emit && !out_stat.emit_ok |=> emit_req.emit && $stable(emit_req.ch))
        else $error("character request changed while stalled");

    // the sequencer never asks for a character while the input side is open
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !emit_req.emit && !emit_req.fin)
        else $error("character request while idle");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import twr_pkg::*;

    // command value with no meaning, must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WORD_DEPTH    = WORD_CAPACITY_DEF;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
    } t_text_item;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_out_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] byte_in
    logic [1:0] i_s_tuser;   // [1:0] command
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [6:0] out_char, [7] zero
    logic       o_m_tlast;

    text_word_wrapper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // stimulus and scoreboard storage
    t_text_item pending_items[$];
    t_out_char  expected_chars[$];
    logic [6:0] step_chars[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_taken    = 0;
    int chars_checked  = 0;
    int error_count    = 0;
    int idle_cycles    = 0;

    // wrapper state as predicted
    logic [7:0] wrap_width;
    logic [6:0] word_buf [WORD_DEPTH];
    logic [5:0] word_len;
    logic [7:0] out_col;
    logic       space_pend;
    logic [1:0] nl_count;
    logic [7:0] lead;
    logic [7:0] src_col;
    logic [7:0] prev_src_len;
    t_basic     basic_state;
    logic       prev_basic;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_width();
        return (wrap_width < MIN_WIDTH) ? int'(MIN_WIDTH) : int'(wrap_width);
    endfunction

    // accented letter after a c3 lead; 80..9f upper case, a0..bf the same letters lower case
    function automatic logic [6:0] fold_accent(input logic [7:0] b);
        logic [4:0] slot;
        logic [6:0] base;
        slot = b[4:0];
        base = CH_NONE;
        if (b[7:6] == 2'b10) begin
            if (slot <= 5) base = 7'h41;                       // A
            else if (slot == 7) base = 7'h43;                  // C
            else if (slot >= 8 && slot <= 11) base = 7'h45;    // E
            else if (slot >= 12 && slot <= 15) base = 7'h49;   // I
            else if (slot == 17) base = 7'h4E;                 // N
            else if (slot >= 18 && slot <= 22) base = 7'h4F;   // O
            else if (slot >= 25 && slot <= 28) base = 7'h55;   // U
            if (base != CH_NONE && b[5]) base = base + 7'd32;
        end
        return base;
    endfunction

    function automatic void put_char(input logic [6:0] c);
        if (step_chars.size() < MAX_RESULTS) step_chars.push_back(c);
    endfunction

    function automatic void break_line();
        put_char(CH_NL);
        out_col = 0;
        space_pend = 1'b0;
    endfunction

    // place the buffered word, splitting it when longer than a line
    function automatic void place_word();
        int w;
        int pos;
        int len;
        int rest;
        int take;
        w = eff_width();
        pos = 0;
        len = word_len;
        while (pos < len) begin
            rest = len - pos;
            if (out_col == 0) begin
                take = (rest > w) ? w : rest;
                for (int k = 0; k < take; k++) put_char(word_buf[pos + k]);
                pos += take;
                out_col = 8'(take);
                space_pend = 1'b0;
                if (pos < len) break_line();
            end else if (int'(out_col) + int'(space_pend) + rest <= w) begin
                if (space_pend) begin
                    put_char(CH_SPACE);
                    out_col++;
                end
                for (int k = 0; k < rest; k++) put_char(word_buf[pos + k]);
                out_col = 8'(int'(out_col) + rest);
                pos = len;
                space_pend = 1'b0;
            end else begin
                break_line();
            end
        end
        word_len = 0;
    endfunction

    // resolve pending source newlines: a space or a hard break
    function automatic void settle_newlines(input logic hard);
        logic [1:0] n;
        n = nl_count;
        nl_count = 0;
        if (n == 1 && !hard) begin
            place_word();
            if (out_col > 0) space_pend = 1'b1;
        end else begin
            place_word();
            if (out_col > 0) break_line();
            if (n >= 2) break_line();
        end
    endfunction

    function automatic void clear_state();
        word_len = 0;
        out_col = 0;
        space_pend = 1'b0;
        nl_count = 0;
        lead = 8'd0;
        src_col = 8'd0;
        prev_src_len = 8'd0;
        basic_state = BD_NONE;
        prev_basic = 1'b0;
    endfunction

    function automatic void accept_byte(input logic [7:0] raw);
        logic [7:0] b;
        logic [7:0] held;
        logic       wrapping;
        logic       hard;
        b = raw;
        // utf-8 lead and continuation handling
        if (lead != 8'd0) begin
            held = lead;
            lead = 8'd0;
            if (held != LEAD_C3) return;
            b = {1'b0, fold_accent(raw)};
            if (b == 8'd0) return;
        end else if (b >= LEAD_MIN) begin
            lead = b;
            return;
        end else if (b >= NON_ASCII) begin
            return;
        end
        // source newline only updates counters
        if (b == {1'b0, CH_NL}) begin
            if (nl_count == 0) begin
                prev_src_len = src_col;
                prev_basic = (basic_state == BD_BASIC);
            end
            if (nl_count < 2) nl_count++;
            src_col = 8'd0;
            basic_state = BD_NONE;
            return;
        end
        if (b < {1'b0, CH_SPACE} || b > {1'b0, CH_MAX}) return;
        if (nl_count != 0) begin
            wrapping = (int'(prev_src_len) + 8 >= eff_width());
            hard = (b == {1'b0, CH_DASH} && word_len == 0) || prev_basic || !wrapping;
            settle_newlines(hard);
        end
        // numbered line detection
        if (basic_state != BD_BASIC) begin
            if (b >= {1'b0, CH_ZERO} && b <= {1'b0, CH_NINE}) begin
                if (src_col < BASIC_COLS) basic_state = BD_DIGITS;
            end else if (b == {1'b0, CH_SPACE} && basic_state == BD_DIGITS) begin
                basic_state = BD_BASIC;
            end else begin
                basic_state = BD_NOT;
            end
        end
        if (src_col < SCOL_MAX) src_col++;
        if (b == {1'b0, CH_SPACE}) begin
            place_word();
            if (out_col > 0) space_pend = 1'b1;
            return;
        end
        if (word_len < WORD_DEPTH) begin
            word_buf[word_len] = b[6:0];
            word_len++;
        end
        if (word_len >= WORD_DEPTH) place_word();
    endfunction

    // expected characters for one accepted transaction
    function automatic void predict_item(input logic [1:0] cmd, input logic [7:0] data);
        t_out_char oc;
        step_chars.delete();
        case (cmd)
            CMD_BYTE: accept_byte(data);
            CMD_END: begin
                nl_count = 0;
                src_col = 8'd0;
                place_word();
                if (out_col > 0) break_line();
            end
            CMD_RESTART: clear_state();
            default: ;
        endcase
        for (int i = 0; i < step_chars.size(); i++) begin
            oc.ch = step_chars[i];
            oc.last = (i == step_chars.size() - 1);
            expected_chars.push_back(oc);
        end
    endfunction

    // sender: one transaction from the pending queue at a time
    always @(posedge i_clk) begin
        t_text_item nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_item(i_s_tuser, i_s_tdata);
                items_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= nxt.cmd;
                    i_s_tdata  <= nxt.data;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_char want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected output, expected none, got tdata %h last %b",
                             $time, o_m_tdata, o_m_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_m_tdata !== {1'b0, want.ch}) begin
                        error_count++;
                        $display("%0t: out_char mismatch, expected %h, got %h",
                                 $time, {1'b0, want.ch}, o_m_tdata);
                    end
                    if (o_m_tlast !== want.last) begin
                        error_count++;
                        $display("%0t: last mismatch, expected %b, got %b",
                                 $time, want.last, o_m_tlast);
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d characters still expected",
                     $time, idle_cycles, expected_chars.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void queue_item(input logic [1:0] cmd, input logic [7:0] data);
        t_text_item it;
        it.cmd = cmd;
        it.data = data;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_byte(input logic [7:0] data);
        queue_item(CMD_BYTE, data);
    endfunction

    function automatic void queue_word(input int len);
        for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(126, 33)));
    endfunction

    // corner cases at the default width
    function automatic void load_directed();
        queue_byte(8'h48);
        queue_byte(8'h7E);
        queue_byte(8'h00);
        queue_byte(8'h7F);
        queue_byte(8'hFF);                 // other lead byte swallows the next byte
        queue_byte(8'h41);
        queue_byte(8'h80);                 // stray continuation byte
        queue_byte(LEAD_C3);
        queue_byte(8'hA9);                 // folds to e
        queue_byte(LEAD_C3);
        queue_byte(8'h89);                 // folds to E
        queue_byte(LEAD_C3);
        queue_byte(8'h86);                 // not a known letter, pair dropped
        queue_byte(8'h20);
        queue_byte(8'h0A);                 // short previous line gives a break
        queue_byte(8'h31);
        queue_byte(8'h30);
        queue_byte(8'h20);
        queue_byte(8'h58);
        queue_byte(8'h0A);
        queue_byte(8'h0A);
        queue_byte(8'h0A);                 // newline count saturates
        queue_byte(8'h61);
        queue_byte(8'h0A);
        queue_byte(8'h2D);                 // dash line
        queue_item(CMD_END, 8'h00);
        queue_item(CMD_RESTART, 8'hFF);
        queue_item(CMD_UNUSED, 8'h5A);
    endfunction

    // one source line long enough to saturate the source column
    function automatic void load_long_line(input int len);
        for (int i = 0; i < len; i++)
            queue_byte((i % 9 == 8) ? 8'h20 : 8'($urandom_range(126, 33)));
        queue_byte(8'h0A);
    endfunction

    // mostly well-formed text with random content, some noise
    function automatic void compose_text(input int count);
        int base;
        int pick;
        int n;
        base = pending_items.size();
        while (pending_items.size() - base < count) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                if ($urandom_range(1)) queue_byte(8'($urandom_range(255)));
                else queue_item(CMD_UNUSED, 8'($urandom_range(255)));
            end else if (pick < 6) begin
                queue_item(CMD_END, 8'($urandom_range(255)));
            end else if (pick < 7) begin
                queue_item(CMD_RESTART, 8'($urandom_range(255)));
            end else if (pick < 14) begin
                n = ($urandom_range(9) < 7) ? 1 : $urandom_range(3, 2);
                for (int i = 0; i < n; i++) queue_byte(8'h0A);
            end else if (pick < 18) begin
                // numbered line
                queue_byte(8'h0A);
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(57, 48)));
                queue_byte(8'h20);
            end else if (pick < 21) begin
                queue_byte(8'h0A);
                queue_byte(8'h2D);
            end else if (pick < 26) begin
                queue_byte(LEAD_C3);
                queue_byte(8'($urandom_range(8'hBF, 8'h80)));
            end else if (pick < 28) begin
                queue_byte(8'($urandom_range(255, 8'hC4)));
                queue_byte(8'($urandom_range(255)));
            end else begin
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(9, 1);
                queue_word(n);
                queue_byte(8'h20);
                if ($urandom_range(9) == 0) queue_byte(8'h20);
            end
        end
    endfunction

    // line width written only while the block is idle
    task automatic set_line_width(input logic [7:0] w);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= w;
        wrap_width = w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_s_tvalid || expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // phases of widths and idle mixes
    initial begin
        logic [7:0] mid_width;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 8'd0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'd0;
        i_s_tuser  = CMD_BYTE;
        i_m_tready = 1'b0;
        wrap_width = WIDTH_RESET;
        clear_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_directed();
        wait_drained();

        set_line_width(MIN_WIDTH);
        send_idle_pct = 83;
        recv_stall_pct = 0;
        compose_text(55);
        wait_drained();

        set_line_width(8'd255);
        send_idle_pct = 0;
        recv_stall_pct = 83;
        load_long_line(262);
        compose_text(30);
        wait_drained();

        mid_width = 8'($urandom_range(254, 17));
        set_line_width(mid_width);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        compose_text(55);
        wait_drained();

        set_line_width(8'd40);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        compose_text(35);
        queue_item(CMD_END, 8'h00);
        wait_drained();

        $display("run covered %0d input transactions and %0d output characters, %0d errors",
                 items_taken, chars_checked, error_count);
        $display("line widths 32, 16, 255, %0d and 40 with sender gaps and receiver stalls",
                 mid_width);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
